// File: sv/erq_pkg.sv
`timescale 1ns / 1ps
package erq_pkg;

  // default number of stored records
  localparam int unsigned QueueDepthDef = 64;
  // width of the fill level field
  localparam int unsigned FillW = 7;

  // one stored record
  typedef struct packed {
    logic        ev;
    logic [31:0] sec;
    logic [29:0] nsec;
    logic [31:0] tag;
  } rec_t;

  localparam int unsigned RecW = $bits(rec_t);

  // result status codes
  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  // request codes
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_WALK,
    S_PLACE,
    S_POP,
    S_DONE
  } fsm_e;

endpackage

// File: sv/erq_ram.sv
`timescale 1ns / 1ps
module erq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/event_reorder_queue_top.sv
`timescale 1ns / 1ps
// A pop reads the head record, and a rejected push or an empty pop goes straight to its
// result; a push takes longer the more stored records it must pass in the search
// and the shift through the record RAM (one entry read and one entry moved per cycle).
// Throughput: one request at a time; the next is taken once its result loads.
// Reset: asynchronous, active low; queue empties, clock_sort clears, RAM untouched.
module event_reorder_queue_top #(
  parameter int unsigned QUEUE_DEPTH = erq_pkg::QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic        is_event_i,
  input  logic        split_piece_i,
  input  logic [31:0] stamp_seconds_i,
  input  logic [29:0] stamp_nanos_i,
  input  logic [31:0] tag_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [31:0] out_tag_o,
  output logic        out_is_event_o,
  output logic [31:0] out_seconds_o,
  output logic [29:0] out_nanos_o,
  output logic [6:0]  fill_level_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_clock_sort_i
);
  import erq_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  fsm_e            state_q, state_d;
  logic [AW-1:0]   head_q, head_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic [CW-1:0]   ridx_q, ridx_d;
  logic [CW-1:0]   pos_q, pos_d;
  logic            rv_q, rv_d;
  logic            walk_ev_q, walk_ev_d;
  logic            pop_q, pop_d;
  status_e         st_q, st_d;
  rec_t            rec_q, rec_d;
  logic            clock_sort_q;

  logic            out_valid_q;
  logic [1:0]      status_q;
  rec_t            out_rec_q;
  logic [6:0]      fill_q;

  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [RecW-1:0] ram_wdata, ram_rdata;
  rec_t            rd;

  logic            in_beat, out_free, later, equal, stop, found;

  // logical position to RAM address, circular from the head
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] l);
    logic [AW+1:0] s;
    s = (AW+2)'(h) + (AW+2)'(l);
    if (s >= (AW+2)'(QUEUE_DEPTH)) begin
      s = s - (AW+2)'(QUEUE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign rd       = rec_t'(ram_rdata);
  assign in_beat  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign later    = {rec_q.sec, rec_q.nsec} > {rd.sec, rd.nsec};
  assign equal    = {rec_q.sec, rec_q.nsec} == {rd.sec, rd.nsec};
  assign stop     = rv_q && walk_ev_q && (!rd.ev || later);
  assign found    = rv_q && equal;

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          if (req_type_i == REQ_POP) begin
            state_d = (count_q == '0) ? S_DONE : S_POP;
          end else if (count_q >= CW'(QUEUE_DEPTH)) begin
            state_d = S_DONE;
          end else if (clock_sort_q && split_piece_i) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_WALK;
          end
        end
      end
      S_SCAN: begin
        if (found || !((idx_q < count_q) || rv_q)) begin
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        if (stop || (idx_q == pos_q && !rv_q)) begin
          state_d = S_PLACE;
        end
      end
      S_PLACE: state_d = S_DONE;
      S_POP:   state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    head_d    = head_q;
    count_d   = count_q;
    idx_d     = idx_q;
    ridx_d    = ridx_q;
    pos_d     = pos_q;
    rv_d      = rv_q;
    walk_ev_d = walk_ev_q;
    pop_d     = pop_q;
    st_d      = st_q;
    rec_d     = rec_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = rec_q;
    ram_re    = 1'b0;
    ram_raddr = '0;
    case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          rec_d     = '{ev: is_event_i, sec: stamp_seconds_i, nsec: stamp_nanos_i, tag: tag_i};
          pop_d     = (req_type_i == REQ_POP);
          st_d      = STAT_DONE;
          rv_d      = 1'b0;
          idx_d     = count_q;
          pos_d     = count_q;
          walk_ev_d = 1'b0;
          if (req_type_i == REQ_POP) begin
            if (count_q == '0) begin
              st_d = STAT_EMPTY;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = head_q;
            end
          end else if (count_q >= CW'(QUEUE_DEPTH)) begin
            st_d = STAT_FULL;
          end else if (clock_sort_q && split_piece_i) begin
            idx_d = '0;
          end else if (clock_sort_q && is_event_i) begin
            walk_ev_d = 1'b1;
            pos_d     = '0;
          end
        end
      end
      // front-to-back search for an equal timestamp
      S_SCAN: begin
        if (found) begin
          pos_d     = ridx_q;
          idx_d     = count_q;
          rv_d      = 1'b0;
          walk_ev_d = 1'b0;
        end else if (idx_q < count_q) begin
          ram_re    = 1'b1;
          ram_raddr = phys(head_q, idx_q);
          ridx_d    = idx_q;
          idx_d     = idx_q + 1'b1;
          rv_d      = 1'b1;
        end else if (rv_q) begin
          rv_d = 1'b0;
        end else begin
          idx_d     = count_q;
          walk_ev_d = rec_q.ev;
          pos_d     = rec_q.ev ? '0 : count_q;
        end
      end
      // tail-to-front walk, moving each passed entry up by one
      S_WALK: begin
        if (stop) begin
          pos_d = ridx_q + 1'b1;
          rv_d  = 1'b0;
        end else begin
          if (rv_q) begin
            ram_we    = 1'b1;
            ram_waddr = phys(head_q, ridx_q + 1'b1);
            ram_wdata = rd;
          end
          if (idx_q > pos_q) begin
            ram_re    = 1'b1;
            ram_raddr = phys(head_q, idx_q - 1'b1);
            ridx_d    = idx_q - 1'b1;
            idx_d     = idx_q - 1'b1;
            rv_d      = 1'b1;
          end else begin
            rv_d = 1'b0;
          end
        end
      end
      S_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = phys(head_q, pos_q);
        ram_wdata = rec_q;
        count_d   = count_q + 1'b1;
      end
      S_POP: begin
        rec_d   = rd;
        count_d = count_q - 1'b1;
        head_d  = ((AW+1)'(head_q) + 1'b1 == (AW+1)'(QUEUE_DEPTH)) ? '0 : head_q + 1'b1;
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      head_q       <= '0;
      count_q      <= '0;
      rv_q         <= 1'b0;
      clock_sort_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      rv_q    <= rv_d;
      if (cfg_valid_i && cfg_ready_o) begin
        clock_sort_q <= cfg_clock_sort_i;
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working payload
  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    ridx_q    <= ridx_d;
    pos_q     <= pos_d;
    walk_ev_q <= walk_ev_d;
    pop_q     <= pop_d;
    st_q      <= st_d;
    rec_q     <= rec_d;
    if (state_q == S_DONE && out_free) begin
      status_q  <= st_q;
      out_rec_q <= (pop_q && st_q == STAT_DONE) ? rec_q : '0;
      fill_q    <= FillW'(count_q);
    end
  end

  erq_ram #(
    .Width (RecW),
    .Depth (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign out_tag_o      = out_rec_q.tag;
  assign out_is_event_o = out_rec_q.ev;
  assign out_seconds_o  = out_rec_q.sec;
  assign out_nanos_o    = out_rec_q.nsec;
  assign fill_level_o   = fill_q;

endmodule

// File: sv/erq_checker.sv
`timescale 1ns / 1ps
module erq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  status_o,
  input logic [31:0] out_tag_o,
  input logic        out_is_event_o,
  input logic [6:0]  fill_level_o
);
  import erq_pkg::*;

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(out_tag_o))
    else $error("stalled result changed");

  // no undefined status code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == STAT_DONE || status_o == STAT_FULL || status_o == STAT_EMPTY))
    else $error("bad status code");

  // pop from empty reports an empty queue and no record
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STAT_EMPTY |-> fill_level_o == '0 && out_tag_o == '0)
    else $error("empty pop result wrong");

  // a rejected push carries no record
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STAT_FULL |-> out_tag_o == '0 && !out_is_event_o)
    else $error("rejected push carries data");

endmodule

bind event_reorder_queue_top erq_checker u_erq_checker (.*);
